// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

  localparam int POLY_SLOTS  = 6;
  localparam int CNT_W       = 3;
  localparam int MAX_PIECES  = 4;
  localparam int ORI_W       = 67;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    pt_t [POLY_SLOTS-1:0] v;
    logic [CNT_W-1:0]     n;
  } poly_t;

endpackage

// ===== rtl/ttc_orient.sv =====
// Exact orientation (b-a)x(p-a), three register stages, one new operand set per cycle.
module ttc_orient import ttc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  pt_t                     a,
  input  pt_t                     b,
  input  pt_t                     p,
  output logic                    vld,
  output logic signed [ORI_W-1:0] w
);

  logic signed [32:0] ex_r, ey_r, px_r, py_r;
  logic signed [65:0] m1_r, m2_r;
  logic signed [ORI_W-1:0] w_r;
  logic v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    ex_r <= 33'(b.x) - 33'(a.x);
    ey_r <= 33'(b.y) - 33'(a.y);
    px_r <= 33'(p.x) - 33'(a.x);
    py_r <= 33'(p.y) - 33'(a.y);
    m1_r <= 66'(ex_r) * 66'(py_r);
    m2_r <= 66'(ey_r) * 66'(px_r);
    w_r  <= ORI_W'(m1_r) - ORI_W'(m2_r);
  end

  assign vld = v3_r;
  assign w   = w_r;

endmodule

// ===== rtl/ttc_cell.sv =====
// One Sutherland-Hodgman pass against the half plane left of e0->e1.
// Corners are handled one at a time; an intersection runs a three-step
// multiply and a 33-step restoring divide for each coordinate.
module ttc_cell import ttc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  poly_t poly_in,
  input  pt_t   e0,
  input  pt_t   e1,
  output logic  done,
  output poly_t poly_out
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ORI  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_MSET = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DSET = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_KEEP = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]  state_r;
  poly_t       pin_r, pout_r;
  pt_t         e0_r, e1_r, prev_r, cur;
  logic signed [ORI_W-1:0] w_r [POLY_SLOTS];
  logic signed [ORI_W-1:0] wprev_r, wcur, ori_w;
  logic        busy_r, done_r, ori_go, ori_vld;
  logic [CNT_W-1:0] idx_r;
  logic [68:0] asp_r;
  logic [67:0] den_r;
  logic        axis_r, dneg_r;
  logic [32:0] ad_r, q_r, nlo_r;
  logic [99:0] acc_r;
  logic [1:0]  mcnt_r;
  logic [68:0] rem_r, d2_r;
  logic [5:0]  dcnt_r;
  coord_t      mx_r;

  logic [ORI_W-1:0] aprev, acur;
  logic        change;
  logic signed [32:0] dv;
  logic [22:0] chunk;
  logic [55:0] prod;
  logic [99:0] prod_sh;
  logic [101:0] nn;
  logic [69:0] trial;
  logic        ge;
  coord_t      pv;
  logic [33:0] rv;

  assign cur    = pin_r.v[idx_r];
  assign wcur   = w_r[idx_r];
  assign ori_go = (state_r == S_ORI) && !busy_r;

  ttc_orient u_ori (
    .clk(clk), .rst_n(rst_n), .go(ori_go),
    .a(e0_r), .b(e1_r), .p(cur),
    .vld(ori_vld), .w(ori_w)
  );

  always_comb begin
    aprev  = wprev_r[ORI_W-1] ? ORI_W'(-wprev_r) : ORI_W'(wprev_r);
    acur   = wcur[ORI_W-1] ? ORI_W'(-wcur) : ORI_W'(wcur);
    // Only a strict sign change puts a crossing point in.
    change = (!wprev_r[ORI_W-1] && (|wprev_r) && wcur[ORI_W-1]) ||
             (wprev_r[ORI_W-1] && !wcur[ORI_W-1] && (|wcur));
    dv     = axis_r ? (33'(cur.y) - 33'(prev_r.y)) : (33'(cur.x) - 33'(prev_r.x));
    case (mcnt_r)
      2'd0:    chunk = asp_r[22:0];
      2'd1:    chunk = asp_r[45:23];
      default: chunk = asp_r[68:46];
    endcase
    prod = 56'(chunk) * 56'(ad_r);
    case (mcnt_r)
      2'd0:    prod_sh = 100'(prod);
      2'd1:    prod_sh = 100'(prod) << 23;
      default: prod_sh = 100'(prod) << 46;
    endcase
    nn    = 102'({acc_r, 1'b0}) + 102'(den_r);
    trial = {rem_r, nlo_r[32]};
    ge    = trial >= {1'b0, d2_r};
    pv    = axis_r ? prev_r.y : prev_r.x;
    rv    = dneg_r ? (34'(pv) - 34'(q_r)) : (34'(pv) + 34'(q_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            pin_r    <= poly_in;
            e0_r     <= e0;
            e1_r     <= e1;
            idx_r    <= '0;
            pout_r.n <= '0;
            state_r  <= (poly_in.n == '0) ? S_FIN : S_ORI;
          end
        end
        S_ORI: begin
          if (ori_go) busy_r <= 1'b1;
          if (ori_vld) begin
            busy_r     <= 1'b0;
            w_r[idx_r] <= ori_w;
            if (idx_r == pin_r.n - CNT_W'(1)) begin
              // The last corner is the first "previous" of the scan.
              wprev_r <= ori_w;
              prev_r  <= cur;
              idx_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              idx_r <= idx_r + CNT_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (change) begin
            asp_r   <= 69'(aprev);
            den_r   <= 68'(aprev) + 68'(acur);
            axis_r  <= 1'b0;
            state_r <= S_MSET;
          end else begin
            state_r <= S_KEEP;
          end
        end
        S_MSET: begin
          dneg_r  <= dv[32];
          ad_r    <= dv[32] ? 33'(-dv) : 33'(dv);
          acc_r   <= '0;
          mcnt_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_r + prod_sh;
          if (mcnt_r == 2'd2) state_r <= S_DSET;
          else mcnt_r <= mcnt_r + 2'd1;
        end
        S_DSET: begin
          // Rounded quotient: (2*num + den) / (2*den), known to fit 33 bits.
          rem_r   <= nn[101:33];
          nlo_r   <= nn[32:0];
          d2_r    <= {den_r, 1'b0};
          q_r     <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? 69'(trial - {1'b0, d2_r}) : trial[68:0];
          q_r   <= {q_r[31:0], ge};
          nlo_r <= {nlo_r[31:0], 1'b0};
          if (dcnt_r == 6'd32) state_r <= S_RES;
          else dcnt_r <= dcnt_r + 6'd1;
        end
        S_RES: begin
          if (!axis_r) begin
            mx_r    <= rv[31:0];
            axis_r  <= 1'b1;
            state_r <= S_MSET;
          end else begin
            if (pout_r.n < CNT_W'(POLY_SLOTS)) begin
              pout_r.v[pout_r.n] <= '{x: mx_r, y: rv[31:0]};
              pout_r.n           <= pout_r.n + CNT_W'(1);
            end
            state_r <= S_KEEP;
          end
        end
        S_KEEP: begin
          if (!wcur[ORI_W-1] && (pout_r.n < CNT_W'(POLY_SLOTS))) begin
            pout_r.v[pout_r.n] <= cur;
            pout_r.n           <= pout_r.n + CNT_W'(1);
          end
          prev_r  <= cur;
          wprev_r <= wcur;
          if (idx_r == pin_r.n - CNT_W'(1)) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_SCAN;
          end
        end
        S_FIN: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign poly_out = pout_r;

endmodule

// ===== rtl/ttc_fan.sv =====
// Fan split from corner 0. A kept piece is held back one step so that the
// last mark is known when it leaves.
module ttc_fan import ttc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  poly_t  poly_in,
  output logic   done,
  output logic   out_valid,
  input  logic   out_ready,
  output pt_t    out_a,
  output pt_t    out_b,
  output pt_t    out_c,
  output logic   out_pv,
  output logic   out_last
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_NEXT = 2'd1;
  localparam logic [1:0] F_ORI  = 2'd2;
  localparam logic [1:0] F_SEND = 2'd3;

  logic [1:0]       state_r;
  poly_t            pin_r;
  pt_t              b_r, cur, pa_r, pb_r, pc_r, oa_r, ob_r, oc_r;
  logic [CNT_W-1:0] k_r, cnt_r, kn, cn;
  logic             pend_r, more_r, busy_r, ov_r, opv_r, olast_r, done_r;
  logic             ori_go, ori_vld, kept;
  logic signed [ORI_W-1:0] ori_w;

  assign cur    = pin_r.v[k_r];
  assign ori_go = (state_r == F_ORI) && !busy_r;
  assign kept   = |ori_w;
  assign kn     = k_r + CNT_W'(1);
  assign cn     = cnt_r + CNT_W'(kept);

  ttc_orient u_ori (
    .clk(clk), .rst_n(rst_n), .go(ori_go),
    .a(pin_r.v[0]), .b(b_r), .p(cur),
    .vld(ori_vld), .w(ori_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
      done_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            pin_r   <= poly_in;
            b_r     <= poly_in.v[1];
            k_r     <= CNT_W'(2);
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            more_r  <= poly_in.n > CNT_W'(2);
            state_r <= F_NEXT;
          end
        end
        F_NEXT: begin
          if (more_r) begin
            state_r <= F_ORI;
          end else begin
            oa_r    <= pend_r ? pa_r : '0;
            ob_r    <= pend_r ? pb_r : '0;
            oc_r    <= pend_r ? pc_r : '0;
            opv_r   <= pend_r;
            olast_r <= 1'b1;
            ov_r    <= 1'b1;
            state_r <= F_SEND;
          end
        end
        F_ORI: begin
          if (ori_go) busy_r <= 1'b1;
          if (ori_vld) begin
            busy_r  <= 1'b0;
            k_r     <= kn;
            b_r     <= cur;
            cnt_r   <= cn;
            more_r  <= (kn < pin_r.n) && (cn < CNT_W'(MAX_PIECES));
            state_r <= F_NEXT;
            if (kept) begin
              pa_r   <= pin_r.v[0];
              pb_r   <= b_r;
              pc_r   <= cur;
              pend_r <= 1'b1;
              if (pend_r) begin
                oa_r    <= pa_r;
                ob_r    <= pb_r;
                oc_r    <= pc_r;
                opv_r   <= 1'b1;
                olast_r <= 1'b0;
                ov_r    <= 1'b1;
                state_r <= F_SEND;
              end
            end
          end
        end
        F_SEND: begin
          if (out_ready) begin
            ov_r <= 1'b0;
            if (olast_r) begin
              done_r  <= 1'b1;
              state_r <= F_IDLE;
            end else begin
              state_r <= F_NEXT;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign done      = done_r;
  assign out_valid = ov_r;
  assign out_a     = oa_r;
  assign out_b     = ob_r;
  assign out_c     = oc_r;
  assign out_pv    = opv_r;
  assign out_last  = olast_r;

endmodule

// ===== rtl/triangle_triangle_clip_fan_top.sv =====
// Clips a subject triangle against a clip triangle (turned counter-clockwise
// first if needed) and returns the clipped polygon as a fan of up to four
// triangles, the last one marked; an empty clip gives one item with
// piece_valid low. Items are handled one at a time: a new item is taken only
// after the last result of the previous one has left. The time per item is set
// by a chain of three clip cells, one per clip edge, each working corner by
// corner: an orientation test and a scan step for every polygon corner, and
// for every crossing point work that is dominated by a 33-step restoring
// divider used once per coordinate.
module triangle_triangle_clip_fan_top import ttc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_subject_ax,
  input  coord_t in_subject_ay,
  input  coord_t in_subject_bx,
  input  coord_t in_subject_by,
  input  coord_t in_subject_cx,
  input  coord_t in_subject_cy,
  input  coord_t in_bound_ax,
  input  coord_t in_bound_ay,
  input  coord_t in_bound_bx,
  input  coord_t in_bound_by,
  input  coord_t in_bound_cx,
  input  coord_t in_bound_cy,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_piece_ax,
  output coord_t out_piece_ay,
  output coord_t out_piece_bx,
  output coord_t out_piece_by,
  output coord_t out_piece_cx,
  output coord_t out_piece_cy,
  output logic   out_piece_valid,
  output logic   out_last_piece
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_ORI  = 2'd1;
  localparam logic [1:0] T_RUN  = 2'd2;

  logic [1:0] state_r;
  poly_t      sub_r, p0, p1, p2;
  pt_t        ba_r, bb_r, bc_r, bb_sel, bc_sel;
  pt_t        oa, ob, oc;
  logic       accept, ori_vld, c0_go, c0_done, c1_done, c2_done, fan_done;
  logic signed [ORI_W-1:0] ori_w;

  assign in_ready = (state_r == T_IDLE);
  assign accept   = in_valid && in_ready;

  ttc_orient u_ori (
    .clk(clk), .rst_n(rst_n), .go(accept),
    .a({in_bound_ax, in_bound_ay}),
    .b({in_bound_bx, in_bound_by}),
    .p({in_bound_cx, in_bound_cy}),
    .vld(ori_vld), .w(ori_w)
  );

  // A clockwise clip triangle has its corners b and c swapped.
  assign bb_sel = ori_w[ORI_W-1] ? bc_r : bb_r;
  assign bc_sel = ori_w[ORI_W-1] ? bb_r : bc_r;
  assign c0_go  = ori_vld && (state_r == T_ORI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            sub_r.v[0] <= '{x: in_subject_ax, y: in_subject_ay};
            sub_r.v[1] <= '{x: in_subject_bx, y: in_subject_by};
            sub_r.v[2] <= '{x: in_subject_cx, y: in_subject_cy};
            for (int i = 3; i < POLY_SLOTS; i++) sub_r.v[i] <= '0;
            sub_r.n    <= CNT_W'(3);
            ba_r       <= '{x: in_bound_ax, y: in_bound_ay};
            bb_r       <= '{x: in_bound_bx, y: in_bound_by};
            bc_r       <= '{x: in_bound_cx, y: in_bound_cy};
            state_r    <= T_ORI;
          end
        end
        T_ORI: begin
          if (ori_vld) begin
            bb_r    <= bb_sel;
            bc_r    <= bc_sel;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (fan_done) state_r <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  ttc_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .start(c0_go), .poly_in(sub_r),
    .e0(ba_r), .e1(bb_sel), .done(c0_done), .poly_out(p0)
  );

  ttc_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .start(c0_done), .poly_in(p0),
    .e0(bb_r), .e1(bc_r), .done(c1_done), .poly_out(p1)
  );

  ttc_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .start(c1_done), .poly_in(p1),
    .e0(bc_r), .e1(ba_r), .done(c2_done), .poly_out(p2)
  );

  ttc_fan u_fan (
    .clk(clk), .rst_n(rst_n), .start(c2_done), .poly_in(p2),
    .done(fan_done), .out_valid(out_valid), .out_ready(out_ready),
    .out_a(oa), .out_b(ob), .out_c(oc),
    .out_pv(out_piece_valid), .out_last(out_last_piece)
  );

  assign out_piece_ax = oa.x;
  assign out_piece_ay = oa.y;
  assign out_piece_bx = ob.x;
  assign out_piece_by = ob.y;
  assign out_piece_cx = oc.x;
  assign out_piece_cy = oc.y;

`ifndef ASSERT_OFF
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("result pending while a new item can be taken");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_piece) |=> !out_valid)
    else $error("result shown after the last piece of an item");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_piece_valid) |-> out_last_piece)
    else $error("empty result not marked last");
`endif

endmodule
